// ===== src/aplt_pkg.sv =====
// shared types, codes and constants of the address pool lease table
`timescale 1ns / 1ps

package aplt_pkg;

    localparam int ADDR_W         = 32;
    localparam int XID_W          = 32;
    localparam int KIND_W         = 2;
    localparam int STATUS_W       = 3;
    localparam int SIZE_W         = 5;
    localparam int POOL_DEPTH_DEF = 16;

    localparam logic [ADDR_W-1:0] BASE_ADDR_RST = 32'hC0A8_6401;
    localparam logic [SIZE_W-1:0] POOL_SIZE_RST = 5'd10;

    localparam logic [KIND_W-1:0] KIND_DISCOVER = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REQUEST  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OFFER    = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ACK      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_NAK      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOFREE   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_BADXID   = 3'd4;
    localparam logic [STATUS_W-1:0] ST_BADKIND  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_RELEASED = 3'd6;

    localparam logic CFG_BASE_ADDR = 1'b0;
    localparam logic CFG_POOL_SIZE = 1'b1;

    typedef struct packed {
        logic load;
        logic scan_start;
        logic scan_run;
        logic update;
        logic res_load;
    } aplt_cmd_t;

    typedef struct packed {
        logic              xid_zero;
        logic [KIND_W-1:0] kind;
        logic              scan_done;
    } aplt_stat_t;

endpackage

// ===== src/aplt_ctrl.sv =====
// controller state machine of the address pool lease table
`timescale 1ns / 1ps

module aplt_ctrl
    import aplt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  aplt_stat_t stat,
    output aplt_cmd_t  cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!stat.xid_zero && stat.kind == KIND_DISCOVER)
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_SCAN;
                end
                else if (out_free)
                begin
                    cmd.update     = 1'b1;
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done && out_free)
                begin
                    cmd.res_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ===== src/aplt_dp.sv =====
// datapath of the address pool lease table: config, lease state, scan and result
`timescale 1ns / 1ps

module aplt_dp
    import aplt_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [ADDR_W-1:0]   cfg_data,
    input  logic [KIND_W-1:0]   kind,
    input  logic [XID_W-1:0]    xid,
    input  logic [ADDR_W-1:0]   requested_addr,
    input  logic [ADDR_W-1:0]   client_addr,
    output logic [STATUS_W-1:0] status,
    output logic [ADDR_W-1:0]   reply_addr,
    output logic [XID_W-1:0]    reply_xid,
    input  aplt_cmd_t           cmd,
    output aplt_stat_t          stat
);

    localparam int IDX_W = $clog2(POOL_DEPTH);
    localparam int CNT_W = $clog2(POOL_DEPTH + 1);
    localparam int SZ_W  = (CNT_W > SIZE_W) ? CNT_W : SIZE_W;

    logic [ADDR_W-1:0]     base_addr_reg;
    logic [SIZE_W-1:0]     pool_size_reg;

    logic [KIND_W-1:0]     kind_reg;
    logic [XID_W-1:0]      xid_reg;
    logic [ADDR_W-1:0]     req_reg;
    logic [ADDR_W-1:0]     cli_reg;

    logic [POOL_DEPTH-1:0] free_reg;
    logic [POOL_DEPTH-1:0] free_next;
    logic [POOL_DEPTH-1:0] ovld_reg;
    logic [POOL_DEPTH-1:0] ovld_next;
    logic [XID_W-1:0]      owner_mem [POOL_DEPTH];

    logic [CNT_W-1:0]      scan_idx_reg;
    logic [CNT_W-1:0]      scan_idx_next;
    logic                  pipe_vld_reg;
    logic                  pipe_vld_next;
    logic                  pipe_free_reg;
    logic                  pipe_ovld_reg;
    logic [IDX_W-1:0]      pipe_idx_reg;
    logic [XID_W-1:0]      pipe_owner_reg;
    logic                  match_found_reg;
    logic                  match_found_next;
    logic                  free_found_reg;
    logic                  free_found_next;
    logic [IDX_W-1:0]      match_idx_reg;
    logic [IDX_W-1:0]      free_idx_reg;

    logic [STATUS_W-1:0]   status_reg;
    logic [ADDR_W-1:0]     reply_addr_reg;
    logic [XID_W-1:0]      reply_xid_reg;

    logic [SZ_W-1:0]       size_ext;
    logic [SZ_W-1:0]       depth_ext;
    logic [CNT_W-1:0]      used_n;
    logic                  xid_zero;
    logic [ADDR_W-1:0]     sel_addr;
    logic [ADDR_W-1:0]     offset;
    logic [IDX_W-1:0]      off_idx;
    logic                  in_pool;
    logic                  ack_ok;
    logic                  issue;
    logic [XID_W-1:0]      pipe_owner_eff;
    logic [IDX_W-1:0]      offer_idx;
    logic [STATUS_W-1:0]   res_status;
    logic [ADDR_W-1:0]     res_addr;

    assign cfg_ready = 1'b1;

    // entries in use
    assign size_ext  = SZ_W'(pool_size_reg);
    assign depth_ext = SZ_W'(POOL_DEPTH);
    assign used_n    = CNT_W'((size_ext > depth_ext) ? depth_ext : size_ext);

    assign xid_zero = (xid_reg == '0);
    assign sel_addr = (kind_reg == KIND_REQUEST) ? req_reg : cli_reg;
    assign offset   = sel_addr - base_addr_reg;
    assign off_idx  = offset[IDX_W-1:0];
    assign in_pool  = offset < ADDR_W'(used_n);
    assign ack_ok   = in_pool && free_reg[off_idx];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_addr_reg <= BASE_ADDR_RST;
            pool_size_reg <= POOL_SIZE_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_BASE_ADDR)
            begin
                base_addr_reg <= cfg_data;
            end
            else if (cfg_index == CFG_POOL_SIZE)
            begin
                pool_size_reg <= cfg_data[SIZE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg <= kind;
            xid_reg  <= xid;
            req_reg  <= requested_addr;
            cli_reg  <= client_addr;
        end
    end

    // lease state updates
    always_comb
    begin
        free_next = free_reg;
        ovld_next = ovld_reg;
        if (cmd.update && !xid_zero)
        begin
            if (kind_reg == KIND_REQUEST && ack_ok)
            begin
                free_next[off_idx] = 1'b0;
                ovld_next[off_idx] = 1'b1;
            end
            else if (kind_reg == KIND_RELEASE && in_pool)
            begin
                free_next[off_idx] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '1;
            ovld_reg <= '0;
        end
        else
        begin
            free_reg <= free_next;
            ovld_reg <= ovld_next;
        end
    end

    // owner id store, one read port for the scan
    always_ff @(posedge clk)
    begin
        if (cmd.update && !xid_zero && kind_reg == KIND_REQUEST && ack_ok)
        begin
            owner_mem[off_idx] <= xid_reg;
        end
        pipe_owner_reg <= owner_mem[scan_idx_reg[IDX_W-1:0]];
        pipe_free_reg  <= free_reg[scan_idx_reg[IDX_W-1:0]];
        pipe_ovld_reg  <= ovld_reg[scan_idx_reg[IDX_W-1:0]];
        pipe_idx_reg   <= scan_idx_reg[IDX_W-1:0];
    end

    // scan pipeline
    assign issue          = cmd.scan_run && (scan_idx_reg < used_n);
    assign pipe_owner_eff = pipe_ovld_reg ? pipe_owner_reg : '0;

    always_comb
    begin
        scan_idx_next    = scan_idx_reg;
        pipe_vld_next    = issue;
        match_found_next = match_found_reg;
        free_found_next  = free_found_reg;
        if (cmd.scan_start)
        begin
            scan_idx_next    = '0;
            pipe_vld_next    = 1'b0;
            match_found_next = 1'b0;
            free_found_next  = 1'b0;
        end
        else
        begin
            if (issue)
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
            end
            if (pipe_vld_reg && pipe_free_reg)
            begin
                free_found_next = 1'b1;
                if (pipe_owner_eff == xid_reg)
                begin
                    match_found_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg    <= '0;
            pipe_vld_reg    <= 1'b0;
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
        end
        else
        begin
            scan_idx_reg    <= scan_idx_next;
            pipe_vld_reg    <= pipe_vld_next;
            match_found_reg <= match_found_next;
            free_found_reg  <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!cmd.scan_start && pipe_vld_reg && pipe_free_reg)
        begin
            if (!free_found_reg)
            begin
                free_idx_reg <= pipe_idx_reg;
            end
            if (!match_found_reg && pipe_owner_eff == xid_reg)
            begin
                match_idx_reg <= pipe_idx_reg;
            end
        end
    end

    // result selection
    assign offer_idx = match_found_reg ? match_idx_reg : free_idx_reg;

    always_comb
    begin
        res_status = ST_BADKIND;
        res_addr   = '0;
        if (xid_zero)
        begin
            res_status = ST_BADXID;
        end
        else
        begin
            case (kind_reg)
                KIND_DISCOVER:
                begin
                    if (match_found_reg || free_found_reg)
                    begin
                        res_status = ST_OFFER;
                        res_addr   = base_addr_reg + ADDR_W'(offer_idx);
                    end
                    else
                    begin
                        res_status = ST_NOFREE;
                    end
                end
                KIND_REQUEST:
                begin
                    if (ack_ok)
                    begin
                        res_status = ST_ACK;
                        res_addr   = req_reg;
                    end
                    else
                    begin
                        res_status = ST_NAK;
                    end
                end
                KIND_RELEASE:
                begin
                    res_status = ST_RELEASED;
                end
                default:
                begin
                    res_status = ST_BADKIND;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            status_reg     <= res_status;
            reply_addr_reg <= res_addr;
            reply_xid_reg  <= xid_reg;
        end
    end

    assign status     = status_reg;
    assign reply_addr = reply_addr_reg;
    assign reply_xid  = reply_xid_reg;

    assign stat.xid_zero  = xid_zero;
    assign stat.kind      = kind_reg;
    assign stat.scan_done = match_found_reg || (!pipe_vld_reg && scan_idx_reg >= used_n);

endmodule

// ===== src/address_pool_lease_table.sv =====
// top level of the address pool lease table
// request, release, bad xid and bad kind items: result loaded without a scan
// discover items: one owner-store read per cycle during the scan; a free entry whose
// last owner id matches ends the scan early
// one item at a time; the next item is taken while the result register waits
// reset: every entry free with owner zero, base 192.168.100.1, pool size 10
`timescale 1ns / 1ps

module address_pool_lease_table
    import aplt_pkg::*;
#(
    parameter int POOL_DEPTH = POOL_DEPTH_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [KIND_W-1:0]   kind,
    input  logic [XID_W-1:0]    xid,
    input  logic [ADDR_W-1:0]   requested_addr,
    input  logic [ADDR_W-1:0]   client_addr,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [ADDR_W-1:0]   reply_addr,
    output logic [XID_W-1:0]    reply_xid,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [ADDR_W-1:0]   cfg_data
);

    aplt_cmd_t  cmd;
    aplt_stat_t stat;

    aplt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    aplt_dp #(
        .POOL_DEPTH (POOL_DEPTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .kind           (kind),
        .xid            (xid),
        .requested_addr (requested_addr),
        .client_addr    (client_addr),
        .status         (status),
        .reply_addr     (reply_addr),
        .reply_xid      (reply_xid),
        .cmd            (cmd),
        .stat           (stat)
    );

endmodule
